>>> src/lca_pkg.sv
// Shared constants, codes and types for the link cluster accumulator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package lca_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    localparam int PIECE_W       = 16;
    localparam int COORD_W       = 31;
    localparam int LIB_W         = 3;
    localparam int WEIGHT_W      = 16;
    localparam int ENTRY_INDEX_W = 10;

    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = '1;
    localparam logic [COORD_W-1:0]  DIST_RESET   = 31'd1000;
    localparam logic [LIB_W-1:0]    LIB_RESET    = 3'd0;

    // register index, taken from paddr[2]
    localparam logic REG_DISTANCE = 1'b0;
    localparam logic REG_LIBRARY  = 1'b1;

    typedef struct packed {
        logic [PIECE_W-1:0] from_piece;
        logic [PIECE_W-1:0] to_piece;
        logic [COORD_W-1:0] first_begin;
        logic [COORD_W-1:0] first_end;
        logic [COORD_W-1:0] second_begin;
        logic [COORD_W-1:0] second_end;
    } lca_item_t;

    typedef struct packed {
        logic [PIECE_W-1:0]  from_piece;
        logic [PIECE_W-1:0]  to_piece;
        logic [LIB_W-1:0]    lib_tag;
        logic [WEIGHT_W-1:0] weight;
        logic [COORD_W-1:0]  first_begin;
        logic [COORD_W-1:0]  first_end;
        logic [COORD_W-1:0]  second_begin;
        logic [COORD_W-1:0]  second_end;
    } lca_row_t;

    typedef struct packed {
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic                     created_new;
        logic [WEIGHT_W-1:0]      entry_weight;
        logic                     table_full;
    } lca_result_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic write_merge;
        logic write_new;
    } lca_cmd_t;

    typedef struct packed {
        logic left;
        logic match;
        logic out_free;
    } lca_stat_t;

endpackage

`default_nettype wire

>>> src/lca_if.sv
// Valid/ready channel interfaces for link beats in and result beats out.
// Depends on lca_pkg for field widths.
`default_nettype none

interface lca_in_if;
    logic                        valid;
    logic                        ready;
    logic [lca_pkg::PIECE_W-1:0] from_piece;
    logic [lca_pkg::PIECE_W-1:0] to_piece;
    logic [lca_pkg::COORD_W-1:0] first_begin;
    logic [lca_pkg::COORD_W-1:0] first_end;
    logic [lca_pkg::COORD_W-1:0] second_begin;
    logic [lca_pkg::COORD_W-1:0] second_end;

    modport source (
        output valid, from_piece, to_piece, first_begin, first_end,
               second_begin, second_end,
        input  ready
    );
    modport sink (
        input  valid, from_piece, to_piece, first_begin, first_end,
               second_begin, second_end,
        output ready
    );
endinterface

interface lca_out_if;
    logic                              valid;
    logic                              ready;
    logic [lca_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic                              created_new;
    logic [lca_pkg::WEIGHT_W-1:0]      entry_weight;
    logic                              table_full;

    modport source (
        output valid, entry_index, created_new, entry_weight, table_full,
        input  ready
    );
    modport sink (
        input  valid, entry_index, created_new, entry_weight, table_full,
        output ready
    );
endinterface

`default_nettype wire

>>> src/lca_cfg.sv
// APB-style register file: cluster distance and current library.
// Depends on lca_pkg.
`default_nettype none

module lca_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lca_pkg::ADDR_W-1:0]  paddr,
    input  logic [lca_pkg::DATA_W-1:0]  pwdata,
    output logic [lca_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [lca_pkg::COORD_W-1:0] distance,
    output logic [lca_pkg::LIB_W-1:0]   cur_library
);

    logic [lca_pkg::COORD_W-1:0] distance_reg;
    logic [lca_pkg::LIB_W-1:0]   library_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg <= lca_pkg::DIST_RESET;
            library_reg  <= lca_pkg::LIB_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == lca_pkg::REG_DISTANCE)
                distance_reg <= pwdata[lca_pkg::COORD_W-1:0];
            else
                library_reg <= pwdata[lca_pkg::LIB_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            lca_pkg::REG_DISTANCE:
                prdata = lca_pkg::DATA_W'(distance_reg);
            lca_pkg::REG_LIBRARY:
                prdata = lca_pkg::DATA_W'(library_reg);
            default:
                prdata = '0;
        endcase
    end

    assign distance    = distance_reg;
    assign cur_library = library_reg;

endmodule

`default_nettype wire

>>> src/lca_ctrl.sv
// Sequencer: accepts a link, steps the table scan, then merges or appends.
// Depends on lca_pkg for the command and status structs.
`default_nettype none

module lca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lca_pkg::lca_stat_t stat,
    output lca_pkg::lca_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_NEW   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // stop issuing once a hit is seen so the hit row stays put
                cmd.issue = stat.left && !stat.match;
                if (stat.match)
                    state_next = S_MERGE;
                else if (!stat.left)
                    state_next = S_NEW;
            end
            S_MERGE:
            begin
                if (stat.out_free)
                begin
                    cmd.write_merge = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_NEW:
            begin
                if (stat.out_free)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> src/lca_datapath.sv
// Link table memory, scan pointer, cluster compare, merge/append and result
// register. Driven by lca_ctrl through lca_cmd_t; depends on lca_pkg.
`default_nettype none

module lca_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lca_pkg::lca_item_t          item_in,
    input  lca_pkg::lca_cmd_t           cmd,
    output lca_pkg::lca_stat_t          stat,
    input  logic [lca_pkg::COORD_W-1:0] distance,
    input  logic [lca_pkg::LIB_W-1:0]   cur_library,
    output lca_pkg::lca_result_t        result,
    output logic                        out_valid,
    input  logic                        out_ready
);

    lca_pkg::lca_row_t   mem [lca_pkg::TABLE_ENTRIES];
    lca_pkg::lca_item_t  item_reg;
    lca_pkg::lca_row_t   rd_row_reg;
    lca_pkg::lca_row_t   wr_row;
    lca_pkg::lca_row_t   merged_row;
    lca_pkg::lca_row_t   new_row;
    lca_pkg::lca_result_t result_reg;
    lca_pkg::lca_result_t result_next;

    logic [lca_pkg::IDX_W-1:0] ptr_reg;
    logic [lca_pkg::IDX_W-1:0] ptr_next;
    logic [lca_pkg::IDX_W-1:0] rd_idx_reg;
    logic [lca_pkg::IDX_W-1:0] wr_addr;
    logic [lca_pkg::CNT_W-1:0] used_reg;
    logic [lca_pkg::CNT_W-1:0] used_next;
    logic [lca_pkg::CNT_W-1:0] used_m1;
    logic                      left_reg;
    logic                      left_next;
    logic                      rd_valid_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      table_is_full;
    logic                      wr_en;
    logic                      hit_first;
    logic                      hit_second;
    logic                      match;

    logic [lca_pkg::COORD_W:0] item_b1_plus;
    logic [lca_pkg::COORD_W:0] row_b1_plus;
    logic [lca_pkg::COORD_W:0] item_b2_plus;
    logic [lca_pkg::COORD_W:0] row_b2_plus;

    assign table_is_full = (used_reg == lca_pkg::CNT_W'(lca_pkg::TABLE_ENTRIES));
    assign used_m1       = used_reg - lca_pkg::CNT_W'(1);

    // |a - b| < d  <=>  a < b + d  and  b < a + d, sums kept one bit wider
    always_comb
    begin
        item_b1_plus = {1'b0, item_reg.first_begin}    + {1'b0, distance};
        row_b1_plus  = {1'b0, rd_row_reg.first_begin}  + {1'b0, distance};
        item_b2_plus = {1'b0, item_reg.second_begin}   + {1'b0, distance};
        row_b2_plus  = {1'b0, rd_row_reg.second_begin} + {1'b0, distance};
        hit_first  = ({1'b0, rd_row_reg.first_begin}  < item_b1_plus) &&
                     ({1'b0, item_reg.first_begin}    < row_b1_plus);
        hit_second = ({1'b0, rd_row_reg.second_begin} < item_b2_plus) &&
                     ({1'b0, item_reg.second_begin}   < row_b2_plus);
        match = rd_valid_reg &&
                (rd_row_reg.from_piece == item_reg.from_piece) &&
                (rd_row_reg.to_piece   == item_reg.to_piece) &&
                (rd_row_reg.lib_tag    == cur_library) &&
                hit_first && hit_second;
    end

    always_comb
    begin
        merged_row = rd_row_reg;
        if (rd_row_reg.weight != lca_pkg::WEIGHT_MAX)
            merged_row.weight = rd_row_reg.weight + lca_pkg::WEIGHT_W'(1);
        if (item_reg.first_begin < rd_row_reg.first_begin)
            merged_row.first_begin = item_reg.first_begin;
        if (item_reg.first_end > rd_row_reg.first_end)
            merged_row.first_end = item_reg.first_end;
        if (item_reg.second_begin < rd_row_reg.second_begin)
            merged_row.second_begin = item_reg.second_begin;
        if (item_reg.second_end > rd_row_reg.second_end)
            merged_row.second_end = item_reg.second_end;

        new_row.from_piece   = item_reg.from_piece;
        new_row.to_piece     = item_reg.to_piece;
        new_row.lib_tag      = cur_library;
        new_row.weight       = lca_pkg::WEIGHT_W'(1);
        new_row.first_begin  = item_reg.first_begin;
        new_row.first_end    = item_reg.first_end;
        new_row.second_begin = item_reg.second_begin;
        new_row.second_end   = item_reg.second_end;
    end

    always_comb
    begin
        wr_en       = cmd.write_merge || (cmd.write_new && !table_is_full);
        wr_addr     = cmd.write_merge ? rd_idx_reg : used_reg[lca_pkg::IDX_W-1:0];
        wr_row      = cmd.write_merge ? merged_row : new_row;
        used_next   = used_reg;
        result_next = result_reg;
        if (cmd.write_merge)
        begin
            result_next.entry_index  = lca_pkg::ENTRY_INDEX_W'(rd_idx_reg);
            result_next.created_new  = 1'b0;
            result_next.entry_weight = merged_row.weight;
            result_next.table_full   = 1'b0;
        end
        else if (cmd.write_new)
        begin
            if (table_is_full)
            begin
                result_next = '0;
                result_next.table_full = 1'b1;
            end
            else
            begin
                used_next = used_reg + lca_pkg::CNT_W'(1);
                result_next.entry_index  =
                    lca_pkg::ENTRY_INDEX_W'(used_reg[lca_pkg::IDX_W-1:0]);
                result_next.created_new  = 1'b1;
                result_next.entry_weight = lca_pkg::WEIGHT_W'(1);
                result_next.table_full   = 1'b0;
            end
        end
    end

    // scan runs from the newest row downwards; first hit is the answer
    always_comb
    begin
        ptr_next  = ptr_reg;
        left_next = left_reg;
        if (cmd.load)
        begin
            ptr_next  = used_m1[lca_pkg::IDX_W-1:0];
            left_next = (used_reg != '0);
        end
        else if (cmd.issue)
        begin
            ptr_next = ptr_reg - lca_pkg::IDX_W'(1);
            if (ptr_reg == '0)
                left_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write_merge || cmd.write_new)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            left_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            left_reg      <= left_next;
            rd_valid_reg  <= cmd.issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        result_reg <= result_next;
        if (cmd.load)
            item_reg <= item_in;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
        if (cmd.issue)
        begin
            rd_row_reg <= mem[ptr_reg];
            rd_idx_reg <= ptr_reg;
        end
    end

    assign stat.left     = left_reg;
    assign stat.match    = match;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign result    = result_reg;
    assign out_valid = out_valid_reg;

    a_issue_has_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> left_reg)
        else $error("read issued with no table row left to scan");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= lca_pkg::CNT_W'(lca_pkg::TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.issue, cmd.write_merge, cmd.write_new}))
        else $error("more than one datapath command at once");

    a_merge_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_merge |=> used_reg == $past(used_reg))
        else $error("merge changed the fill count");

    a_append_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new && !table_is_full |=>
            used_reg == $past(used_reg) + lca_pkg::CNT_W'(1))
        else $error("append did not advance the fill count by one");

endmodule

`default_nettype wire

>>> src/link_cluster_accumulator_top.sv
// Link cluster accumulator: top level joining registers, sequencer and datapath.
// Depends on lca_pkg, lca_if, lca_cfg, lca_ctrl and lca_datapath.
//
// Usage:
//   links   - valid/ready input; one beat is one read-pair link with its spans.
//   results - valid/ready output; exactly one beat per link: entry index,
//             created flag, weight after the link and a table-full flag.
//   APB     - cluster_distance at 0x0, current_library at 0x4; write only
//             while no link is in flight.
// Flow: a link is accepted and loaded, the table scan follows, then a merge
//   into the hit row or an append, and the result goes to the output register.
//   The table memory has one read port and the scan reads one row a cycle,
//   newest first, stopping at the first cluster hit.
// Throughput: one link at a time; the next is taken the cycle after the
//   previous result is loaded into the output register.
// Reset: rst_n clears the row count, so the table starts empty, and restores
//   register defaults (distance 1000, library 0). No clearing pass.
// Stall: a held result beat lets one further link be accepted and scanned;
//   its write-back and result wait until the output register is free.
`default_nettype none

module link_cluster_accumulator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lca_pkg::ADDR_W-1:0] paddr,
    input  logic [lca_pkg::DATA_W-1:0] pwdata,
    output logic [lca_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    lca_in_if.sink                     links,
    lca_out_if.source                  results
);

    logic [lca_pkg::COORD_W-1:0] distance;
    logic [lca_pkg::LIB_W-1:0]   cur_library;
    lca_pkg::lca_cmd_t           cmd;
    lca_pkg::lca_stat_t          stat;
    lca_pkg::lca_item_t          item;
    lca_pkg::lca_result_t        result;
    logic                        in_ready;
    logic                        out_valid;

    assign item.from_piece   = links.from_piece;
    assign item.to_piece     = links.to_piece;
    assign item.first_begin  = links.first_begin;
    assign item.first_end    = links.first_end;
    assign item.second_begin = links.second_begin;
    assign item.second_end   = links.second_end;
    assign links.ready       = in_ready;

    lca_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .distance    (distance),
        .cur_library (cur_library)
    );

    lca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (links.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lca_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_in     (item),
        .cmd         (cmd),
        .stat        (stat),
        .distance    (distance),
        .cur_library (cur_library),
        .result      (result),
        .out_valid   (out_valid),
        .out_ready   (results.ready)
    );

    assign results.valid        = out_valid;
    assign results.entry_index  = result.entry_index;
    assign results.created_new  = result.created_new;
    assign results.entry_weight = result.entry_weight;
    assign results.table_full   = result.table_full;

endmodule

`default_nettype wire

>>> sim/link_cluster_accumulator_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for link_cluster_accumulator_top: link beats in, result beats out,
// APB register writes between phases; a table model predicts every result beat.
// Depends on lca_pkg, lca_if and the block's RTL.

module link_cluster_accumulator_top_test;

    localparam longint LIMIT_CYCLES = 2_000_000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     POOL_DEPTH   = 32;
    localparam logic [lca_pkg::COORD_W-1:0] COORD_MAX = '1;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lca_pkg::ADDR_W-1:0] paddr;
    logic [lca_pkg::DATA_W-1:0] pwdata;
    logic [lca_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    lca_in_if  links_ch ();
    lca_out_if results_ch ();

    link_cluster_accumulator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .links   (links_ch),
        .results (results_ch)
    );

    // table model
    lca_pkg::lca_row_t           rows_mdl [lca_pkg::TABLE_ENTRIES];
    int                          rows_used = 0;
    logic [lca_pkg::COORD_W-1:0] dist_cfg  = lca_pkg::DIST_RESET;
    logic [lca_pkg::LIB_W-1:0]   lib_cfg   = lca_pkg::LIB_RESET;

    lca_pkg::lca_result_t awaited_results [$];
    lca_pkg::lca_item_t   recent_links [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        holding;
    int          fail_count  = 0;
    longint      cycle_count = 0;
    event        hold_trigger;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[link_cluster_accumulator_top] ERROR");
            $finish;
        end
    end

    function automatic logic [lca_pkg::COORD_W-1:0] coord_gap(
        input logic [lca_pkg::COORD_W-1:0] a,
        input logic [lca_pkg::COORD_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Newest row with same pieces, current library and both begins within distance.
    function automatic lca_pkg::lca_result_t accumulate_link(input lca_pkg::lca_item_t lk);
        lca_pkg::lca_result_t res;
        int          hit;
        int          i;
        res = '0;
        hit = -1;
        for (i = rows_used - 1; i >= 0 && hit < 0; i--)
        begin
            if (rows_mdl[i].from_piece == lk.from_piece && rows_mdl[i].to_piece == lk.to_piece
                && rows_mdl[i].lib_tag == lib_cfg
                && coord_gap(lk.first_begin, rows_mdl[i].first_begin) < dist_cfg
                && coord_gap(lk.second_begin, rows_mdl[i].second_begin) < dist_cfg)
                hit = i;
        end
        if (hit < 0)
        begin
            if (rows_used >= lca_pkg::TABLE_ENTRIES)
            begin
                res.table_full = 1'b1;
                return res;
            end
            hit = rows_used;
            rows_used++;
            rows_mdl[hit] = '{from_piece: lk.from_piece, to_piece: lk.to_piece,
                              lib_tag: lib_cfg, weight: '0,
                              first_begin: lk.first_begin, first_end: lk.first_end,
                              second_begin: lk.second_begin, second_end: lk.second_end};
            res.created_new = 1'b1;
        end
        if (rows_mdl[hit].weight != lca_pkg::WEIGHT_MAX)
            rows_mdl[hit].weight++;
        if (lk.first_begin < rows_mdl[hit].first_begin)
            rows_mdl[hit].first_begin = lk.first_begin;
        if (lk.first_end > rows_mdl[hit].first_end)
            rows_mdl[hit].first_end = lk.first_end;
        if (lk.second_begin < rows_mdl[hit].second_begin)
            rows_mdl[hit].second_begin = lk.second_begin;
        if (lk.second_end > rows_mdl[hit].second_end)
            rows_mdl[hit].second_end = lk.second_end;
        res.entry_index  = lca_pkg::ENTRY_INDEX_W'(hit);
        res.entry_weight = rows_mdl[hit].weight;
        return res;
    endfunction

    function automatic lca_pkg::lca_item_t link_of(input logic [lca_pkg::PIECE_W-1:0] from_p,
                                                   input logic [lca_pkg::PIECE_W-1:0] to_p,
                                                   input logic [lca_pkg::COORD_W-1:0] b1,
                                                   input logic [lca_pkg::COORD_W-1:0] e1,
                                                   input logic [lca_pkg::COORD_W-1:0] b2,
                                                   input logic [lca_pkg::COORD_W-1:0] e2);
        return '{from_piece: from_p, to_piece: to_p, first_begin: b1, first_end: e1,
                 second_begin: b2, second_end: e2};
    endfunction

    function automatic logic [lca_pkg::COORD_W-1:0] near_coord(
        input logic [lca_pkg::COORD_W-1:0] base,
        input longint offset);
        longint v;
        v = longint'(base) + ($urandom_range(0, 1) ? offset : -offset);
        if (v < 0)
            v = 0;
        if (v > longint'(COORD_MAX))
            v = longint'(COORD_MAX);
        return v[lca_pkg::COORD_W-1:0];
    endfunction

    // begin offsets straddle the cluster distance
    function automatic longint begin_offset();
        case ($urandom_range(0, 3))
            0:       return longint'(dist_cfg) - 1;
            1:       return longint'(dist_cfg);
            default: return longint'($urandom_range(0, dist_cfg));
        endcase
    endfunction

    // Mostly variations on recent links so that clusters form; the rest is fresh noise.
    function automatic lca_pkg::lca_item_t make_link();
        lca_pkg::lca_item_t lk;
        lca_pkg::lca_item_t seed;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 60 && recent_links.size() != 0)
        begin
            seed            = recent_links[$urandom_range(0, recent_links.size() - 1)];
            lk              = seed;
            lk.first_begin  = near_coord(seed.first_begin, begin_offset());
            lk.second_begin = near_coord(seed.second_begin, begin_offset());
            lk.first_end    = near_coord(seed.first_end, $urandom_range(0, 4095));
            lk.second_end   = near_coord(seed.second_end, $urandom_range(0, 4095));
        end
        else
        begin
            lk.from_piece   = lca_pkg::PIECE_W'($urandom);
            lk.to_piece     = lca_pkg::PIECE_W'($urandom);
            lk.first_begin  = lca_pkg::COORD_W'($urandom);
            lk.first_end    = lca_pkg::COORD_W'($urandom);
            lk.second_begin = lca_pkg::COORD_W'($urandom);
            lk.second_end   = lca_pkg::COORD_W'($urandom);
            if (pick < 80)
            begin
                lk.from_piece = lca_pkg::PIECE_W'($urandom_range(0, 15));
                lk.to_piece   = lca_pkg::PIECE_W'($urandom_range(0, 15));
            end
        end
        return lk;
    endfunction

    task automatic report_fail(input string msg);
        fail_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic offer_link(input lca_pkg::lca_item_t lk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            links_ch.valid <= 1'b0;
            @(posedge clk);
        end
        links_ch.valid        <= 1'b1;
        links_ch.from_piece   <= lk.from_piece;
        links_ch.to_piece     <= lk.to_piece;
        links_ch.first_begin  <= lk.first_begin;
        links_ch.first_end    <= lk.first_end;
        links_ch.second_begin <= lk.second_begin;
        links_ch.second_end   <= lk.second_end;
        do
            @(posedge clk);
        while (!links_ch.ready);
        awaited_results = {awaited_results, accumulate_link(lk)};
        recent_links    = {recent_links, lk};
        if (recent_links.size() > POOL_DEPTH)
            void'(recent_links.pop_front());
    endtask

    task automatic wait_results_drained();
        links_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Only written with the block idle, so drain first; read back afterwards.
    task automatic write_register(input logic reg_idx,
                                  input logic [lca_pkg::DATA_W-1:0] value);
        logic [lca_pkg::DATA_W-1:0] exp_rd;
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == lca_pkg::REG_DISTANCE)
        begin
            dist_cfg = value[lca_pkg::COORD_W-1:0];
            exp_rd   = lca_pkg::DATA_W'(dist_cfg);
        end
        else
        begin
            lib_cfg = value[lca_pkg::LIB_W-1:0];
            exp_rd  = lca_pkg::DATA_W'(lib_cfg);
        end
        @(posedge clk);
        if (!pready || prdata !== exp_rd)
            report_fail($sformatf("register %0b read back %0h expected %0h",
                                  reg_idx, prdata, exp_rd));
    endtask

    task automatic check_result();
        lca_pkg::lca_result_t exp_res;
        if (awaited_results.size() == 0)
        begin
            report_fail($sformatf("result beat with nothing outstanding: index %0d",
                                  results_ch.entry_index));
            return;
        end
        exp_res = awaited_results.pop_front();
        if (results_ch.entry_index !== exp_res.entry_index)
            report_fail($sformatf("entry_index got %0d expected %0d",
                                  results_ch.entry_index, exp_res.entry_index));
        if (results_ch.created_new !== exp_res.created_new)
            report_fail($sformatf("created_new got %0b expected %0b",
                                  results_ch.created_new, exp_res.created_new));
        if (results_ch.entry_weight !== exp_res.entry_weight)
            report_fail($sformatf("entry_weight got %0d expected %0d",
                                  results_ch.entry_weight, exp_res.entry_weight));
        if (results_ch.table_full !== exp_res.table_full)
            report_fail($sformatf("table_full got %0b expected %0b",
                                  results_ch.table_full, exp_res.table_full));
    endtask

    always @(posedge clk)
    begin
        if (results_ch.valid && results_ch.ready)
            check_result();
        results_ch.ready <= rst_n && !holding && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted here
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_trigger);
            @(posedge clk);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    task automatic test_directed_clusters();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_link(link_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        offer_link(link_of(16'hFFFF, 16'hFFFF, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        offer_link(link_of(16'h0000, 16'h0000, 999, 10, 999, 10));
        // first begin exactly at the distance: no merge
        offer_link(link_of(16'h0000, 16'h0000, 1000, 20, 0, 20));
        // within reach of two rows, the newer one takes it
        offer_link(link_of(16'h0000, 16'h0000, 500, 5, 500, 30));
        offer_link(link_of(16'hFFFF, 16'hFFFF, COORD_MAX - 31'd999, COORD_MAX - 31'd5,
                           COORD_MAX - 31'd1, 0));
        // begins above ends are kept as given
        offer_link(link_of(16'h0005, 16'h0006, 100, 50, 200, 20));
        offer_link(link_of(16'h0005, 16'h0006, 90, 300, 210, 10));
        offer_link(link_of(16'h0006, 16'h0005, 100, 50, 200, 20));
        offer_link(link_of(16'h0005, 16'h0006, 100, 50, 1300, 20));
        offer_link(link_of(16'h8000, 16'h0001, 31'h4000_0000, 31'h2AAA_AAAA,
                           31'h5555_5555, 0));
    endtask

    task automatic test_register_settings();
        write_register(lca_pkg::REG_LIBRARY, '1);
        offer_link(link_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        offer_link(link_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        write_register(lca_pkg::REG_DISTANCE, '1);
        offer_link(link_of(16'h0000, 16'h0000, COORD_MAX - 31'd1, COORD_MAX,
                           COORD_MAX - 31'd1, 1));
        // zero distance: nothing merges
        write_register(lca_pkg::REG_DISTANCE, '0);
        offer_link(link_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        write_register(lca_pkg::REG_DISTANCE, 1);
        offer_link(link_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        offer_link(link_of(16'h0000, 16'h0000, 1, 0, 0, 0));
        write_register(lca_pkg::REG_DISTANCE, lca_pkg::DATA_W'(lca_pkg::DIST_RESET));
        write_register(lca_pkg::REG_LIBRARY, lca_pkg::DATA_W'(lca_pkg::LIB_RESET));
        offer_link(link_of(16'h0000, 16'h0000, 10, 3, 10, 3));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_trigger;
        repeat (10) offer_link(make_link());
        // sender stands back until every result is in
        wait_results_drained();
        repeat (5) offer_link(make_link());
    endtask

    task automatic test_weight_growth();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(lca_pkg::REG_LIBRARY, 2);
        repeat (40)
            offer_link(link_of(16'h5A5A, 16'hA5A5, 123456, 200000, 654321, 700000));
    endtask

    task automatic test_random_links();
        write_register(lca_pkg::REG_DISTANCE, lca_pkg::DATA_W'(lca_pkg::DIST_RESET));
        write_register(lca_pkg::REG_LIBRARY, 3);
        send_idle_pct = 38;
        recv_idle_pct = 71;
        repeat (170) offer_link(make_link());
        write_register(lca_pkg::REG_DISTANCE, 50000);
        send_idle_pct = 71;
        recv_idle_pct = 38;
        repeat (170) offer_link(make_link());
        write_register(lca_pkg::REG_DISTANCE, 1);
        write_register(lca_pkg::REG_LIBRARY, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (170) offer_link(make_link());
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        links_ch.valid          = 1'b0;
        links_ch.from_piece     = '0;
        links_ch.to_piece       = '0;
        links_ch.first_begin    = '0;
        links_ch.first_end      = '0;
        links_ch.second_begin   = '0;
        links_ch.second_end     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_clusters();
        test_register_settings();
        test_backpressure();
        test_weight_growth();
        test_random_links();

        wait_results_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("[link_cluster_accumulator_top] OK");
        else
            $display("[link_cluster_accumulator_top] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/lca_pkg.sv
src/lca_if.sv
src/lca_cfg.sv
src/lca_ctrl.sv
src/lca_datapath.sv
src/link_cluster_accumulator_top.sv
sim/link_cluster_accumulator_top_test.sv
